### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on the rising clock edge, off during reset
`define HPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication, off during reset
`define HPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/hpe_pkg.sv
// shared types, constants and helper functions for the heartbeat envelope
package hpe_pkg;

    // strip length clamp
    localparam int MAX_LEDS = 256;

    // configuration register indexes
    localparam logic [2:0] REG_BASE_RED    = 3'd0;
    localparam logic [2:0] REG_BASE_GREEN  = 3'd1;
    localparam logic [2:0] REG_BASE_BLUE   = 3'd2;
    localparam logic [2:0] REG_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_TARGET_LED  = 3'd4;
    localparam logic [2:0] REG_STRIP_LEN   = 3'd5;

    // envelope phase codes
    localparam logic [2:0] PH_RISE1 = 3'd0;
    localparam logic [2:0] PH_FALL1 = 3'd1;
    localparam logic [2:0] PH_PAUSE = 3'd2;
    localparam logic [2:0] PH_RISE2 = 3'd3;
    localparam logic [2:0] PH_FALL2 = 3'd4;
    localparam logic [2:0] PH_GAP   = 3'd5;

    // phase durations in ms
    localparam logic [8:0] T_RISE1 = 9'd80;
    localparam logic [8:0] T_FALL1 = 9'd120;
    localparam logic [8:0] T_PAUSE = 9'd80;
    localparam logic [8:0] T_RISE2 = 9'd60;
    localparam logic [8:0] T_FALL2 = 9'd140;
    localparam logic [8:0] T_GAP   = 9'd400;

    // ramp reciprocals, 2^26 / duration rounded up; exact for every timer * 255 in range
    localparam int          RCP_SHIFT = 26;
    localparam logic [20:0] RCP_RISE1 = 21'd838861;
    localparam logic [20:0] RCP_FALL1 = 21'd559241;
    localparam logic [20:0] RCP_PAUSE = 21'd838861;
    localparam logic [20:0] RCP_RISE2 = 21'd1118482;
    localparam logic [20:0] RCP_FALL2 = 21'd479350;
    localparam logic [20:0] RCP_GAP   = 21'd167773;

    // brightness levels
    localparam logic [7:0] LVL_FALL1_FLOOR = 8'd40;
    localparam logic [7:0] LVL_PAUSE       = 8'd30;
    localparam logic [7:0] LVL_RISE2_SCALE = 8'd200;
    localparam logic [7:0] LVL_FALL2_TOP   = 8'd200;
    localparam logic [7:0] LVL_FALL2_FLOOR = 8'd20;
    localparam logic [7:0] LVL_GAP         = 8'd15;
    localparam logic [7:0] LVL_FULL        = 8'd255;

    // register file contents
    typedef struct packed {
        logic [7:0]  base_red;
        logic [7:0]  base_green;
        logic [7:0]  base_blue;
        logic [15:0] interval;
        logic [8:0]  target_led;
        logic [8:0]  strip_length;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic phase;
        logic div;
        logic square;
        logic cube;
        logic bright;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic due;
        logic out_free;
        logic strip_nz;
    } t_sts;

    // duration of a phase; unused codes behave as the long gap
    function automatic logic [8:0] dur_of(input logic [2:0] ph);
        logic [8:0] d;
        case (ph)
            PH_RISE1: d = T_RISE1;
            PH_FALL1: d = T_FALL1;
            PH_PAUSE: d = T_PAUSE;
            PH_RISE2: d = T_RISE2;
            PH_FALL2: d = T_FALL2;
            default:  d = T_GAP;
        endcase
        return d;
    endfunction

    // ramp reciprocal of a phase; unused codes behave as the long gap
    function automatic logic [20:0] recip_of(input logic [2:0] ph);
        logic [20:0] m;
        case (ph)
            PH_RISE1: m = RCP_RISE1;
            PH_FALL1: m = RCP_FALL1;
            PH_PAUSE: m = RCP_PAUSE;
            PH_RISE2: m = RCP_RISE2;
            PH_FALL2: m = RCP_FALL2;
            default:  m = RCP_GAP;
        endcase
        return m;
    endfunction

    // phase that follows a completed phase
    function automatic logic [2:0] next_of(input logic [2:0] ph);
        logic [2:0] n;
        case (ph)
            PH_RISE1: n = PH_FALL1;
            PH_FALL1: n = PH_PAUSE;
            PH_PAUSE: n = PH_RISE2;
            PH_RISE2: n = PH_FALL2;
            PH_FALL2: n = PH_GAP;
            default:  n = PH_RISE1;
        endcase
        return n;
    endfunction

endpackage

### rtl/hpe_regs.sv
// configuration register file
module hpe_regs import hpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_red     <= 8'd255;
            r_cfg.base_green   <= 8'd0;
            r_cfg.base_blue    <= 8'd0;
            r_cfg.interval     <= 16'd20;
            r_cfg.target_led   <= 9'h1FF;
            r_cfg.strip_length <= 9'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_RED:   r_cfg.base_red     <= i_cfg_data[7:0];
                REG_BASE_GREEN: r_cfg.base_green   <= i_cfg_data[7:0];
                REG_BASE_BLUE:  r_cfg.base_blue    <= i_cfg_data[7:0];
                REG_INTERVAL:   r_cfg.interval     <= i_cfg_data;
                REG_TARGET_LED: r_cfg.target_led   <= i_cfg_data[8:0];
                REG_STRIP_LEN:  r_cfg.strip_length <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/hpe_ctrl.sv
// sequencing state machine for one envelope update
module hpe_ctrl import hpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_DIV,
        S_SQUARE,
        S_CUBE,
        S_BRIGHT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.phase    = (r_state == S_PHASE);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.square   = (r_state == S_SQUARE);
        o_cmd.cube     = (r_state == S_CUBE);
        o_cmd.bright   = (r_state == S_BRIGHT);
        o_cmd.load_out = (r_state == S_OUT) && i_sts.strip_nz && i_sts.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.due) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE:  n_state = S_DIV;
            S_DIV:    n_state = S_SQUARE;
            S_SQUARE: n_state = S_CUBE;
            S_CUBE:   n_state = S_BRIGHT;
            S_BRIGHT: n_state = S_OUT;
            S_OUT: begin
                // empty strip drops the result, otherwise wait for a free slot
                if (!i_sts.strip_nz || i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/hpe_dp.sv
// envelope datapath: timers, ramp reciprocal, cubic easing, colour scaling
module hpe_dp import hpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [9:0] i_ms_advance,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_write_all,
    output logic [7:0] o_led_position
);

    // envelope state
    logic [15:0] r_since;
    logic [2:0]  r_phase;
    logic [15:0] r_timer;

    // working registers
    logic [2:0]  r_kind;
    logic [16:0] r_num;
    logic [20:0] r_recip;
    logic [7:0]  r_quot;
    logic [7:0]  r_q;
    logic [15:0] r_sq;
    logic [7:0]  r_e;
    logic [7:0]  r_bright;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic        r_all;
    logic [7:0]  r_pos;

    logic [16:0] sum_ext;
    logic [15:0] since_sat;
    logic [8:0]  cur_dur;
    logic        wrap;
    logic [8:0]  timer_eff;
    logic [16:0] num;
    logic [37:0] ramp_prod;
    logic [7:0]  q_val;
    logic [23:0] cube;
    logic [6:0]  e_frac;
    logic [7:0]  e_inv;
    logic [15:0] rise2_prod;
    logic [7:0]  fall2_val;
    logic [7:0]  n_bright;
    logic [8:0]  bright_p1;
    logic [16:0] prod_r;
    logic [16:0] prod_g;
    logic [16:0] prod_b;
    logic        in_range;

    // saturating accumulate of elapsed time
    assign sum_ext   = {1'b0, r_since} + {7'd0, i_ms_advance};
    assign since_sat = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];

    assign o_sts.due      = (since_sat >= i_cfg.interval);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.strip_nz = (i_cfg.strip_length != 9'd0);

    // phase advance and ramp numerator timer * 255
    assign cur_dur   = dur_of(r_phase);
    assign wrap      = (r_timer >= {7'd0, cur_dur});
    assign timer_eff = wrap ? 9'd0 : r_timer[8:0];
    assign num       = {timer_eff, 8'd0} - {8'd0, timer_eff};

    // ramp position by reciprocal multiplication
    assign ramp_prod = {21'd0, r_num} * {17'd0, r_recip};

    // folded easing input
    assign q_val = {(r_quot[7] ? ~r_quot[6:0] : r_quot[6:0]), 1'b0};
    assign cube  = r_sq * {16'd0, r_q};
    assign e_frac = cube[23:17];

    // brightness per phase kind
    assign e_inv      = LVL_FULL - r_e;
    assign rise2_prod = r_e * (LVL_RISE2_SCALE + 8'd1);
    assign fall2_val  = (r_e >= LVL_FALL2_TOP) ? 8'd0 : (LVL_FALL2_TOP - r_e);

    always_comb begin
        case (r_kind)
            PH_RISE1: n_bright = r_e;
            PH_FALL1: n_bright = (e_inv < LVL_FALL1_FLOOR) ? LVL_FALL1_FLOOR : e_inv;
            PH_PAUSE: n_bright = LVL_PAUSE;
            PH_RISE2: n_bright = rise2_prod[15:8];
            PH_FALL2: n_bright = (fall2_val < LVL_FALL2_FLOOR) ? LVL_FALL2_FLOOR : fall2_val;
            default:  n_bright = LVL_GAP;
        endcase
    end

    // colour scaling and target selection
    assign bright_p1 = {1'b0, r_bright} + 9'd1;
    assign prod_r    = i_cfg.base_red * bright_p1;
    assign prod_g    = i_cfg.base_green * bright_p1;
    assign prod_b    = i_cfg.base_blue * bright_p1;
    assign in_range  = !i_cfg.target_led[8]
                    && ({1'b0, i_cfg.target_led[7:0]} < i_cfg.strip_length)
                    && ({24'd0, i_cfg.target_led[7:0]} < MAX_LEDS);

    // envelope state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= 16'd0;
            r_phase <= PH_RISE1;
            r_timer <= 16'd0;
        end else if (i_cmd.accept) begin
            if (o_sts.due) begin
                r_since <= 16'd0;
                r_timer <= r_timer + since_sat;
            end else begin
                r_since <= since_sat;
            end
        end else if (i_cmd.phase && wrap) begin
            r_timer <= 16'd0;
            r_phase <= next_of(r_phase);
        end
    end

    // ramp and easing pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.phase) begin
            r_kind  <= r_phase;
            r_num   <= num;
            r_recip <= recip_of(r_phase);
        end
        if (i_cmd.div) begin
            r_quot <= ramp_prod[RCP_SHIFT+7:RCP_SHIFT];
        end
        if (i_cmd.square) begin
            r_q  <= q_val;
            r_sq <= q_val * q_val;
        end
        if (i_cmd.cube) begin
            r_e <= r_quot[7] ? (LVL_FULL - {1'b0, e_frac}) : {1'b0, e_frac};
        end
        if (i_cmd.bright) begin
            r_bright <= n_bright;
        end
    end

    // result register with handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_red   <= prod_r[15:8];
            r_green <= prod_g[15:8];
            r_blue  <= prod_b[15:8];
            r_all   <= !in_range;
            r_pos   <= in_range ? i_cfg.target_led[7:0] : 8'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_write_all    = r_all;
    assign o_led_position = r_pos;

endmodule

### rtl/heartbeat_pulse_envelope.sv
// heartbeat pulse envelope top level
// An input item that does not make an update due is taken and gives no result.
// An item that makes an update due is worked in steps: accumulate, advance the phase and
// form timer * 255, the reciprocal multiply that gives the ramp position, then square,
// cube, brightness and colour scaling, in that order. The finished result sits
// in an output register, so the next item can be taken while it waits; a new result waits in
// the last step only while the previous one is still untaken. Configuration is taken in every
// cycle.
module heartbeat_pulse_envelope import hpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] ms_advance, [15:10] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_red, [15:8] out_green,
                                        // [23:16] out_blue, [31:24] led_position
    output logic        m_axis_tuser,   // [0] write_all
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pos;

    hpe_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hpe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_ms_advance   (s_axis_tdata[9:0]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .o_write_all    (m_axis_tuser),
        .o_led_position (pos)
    );

    // pack result fields
    assign m_axis_tdata = {pos, blue, green, red};

endmodule

### rtl/hpe_checker.sv
// port-level checks for the heartbeat envelope, bound to the top level
`include "assert_macros.svh"

module hpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result holds its payload
    `HPE_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // whole-strip writes carry a zero position
    `HPE_ASSERT_IMP(a_all_pos, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:24] == 8'd0, "write_all with non-zero position")

    // a new result comes from the last pipeline step, never straight after an input transaction
    `HPE_ASSERT_IMP(a_no_early, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready), "result appeared straight after input transaction")

    // input ready does not drop without an input transaction
    `HPE_ASSERT(a_busy, i_clk, i_rst_n, s_axis_tready && !s_axis_tvalid |=> s_axis_tready, "input ready dropped without a transaction")

endmodule

bind heartbeat_pulse_envelope hpe_checker u_hpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
